[design/chib_pkg.sv]
// ----------------------------------------------------------------------------
// chib_pkg
// Op codes and register indexes shared by the halo index builder files.
// ----------------------------------------------------------------------------
package chib_pkg;

    typedef logic [2:0] op_t;

    localparam op_t OP_GRAPH_NBR  = 3'd0;
    localparam op_t OP_GRAPH_CNT  = 3'd1;
    localparam op_t OP_SECOND_NBR = 3'd2;
    localparam op_t OP_SECOND_CNT = 3'd3;
    localparam op_t OP_APPEND     = 3'd4;
    localparam op_t OP_RUN        = 3'd5;
    localparam op_t OP_READ       = 3'd6;

    localparam logic CFG_DOUBLE_JUMP = 1'b0;
    localparam logic CFG_USE_SECOND  = 1'b1;

endpackage

[design/chib_ram.sv]
// ----------------------------------------------------------------------------
// chib_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chib_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/core_halo_index_builder.sv]
// ----------------------------------------------------------------------------
// core_halo_index_builder
// Builds a core plus two-hop halo index list from two adjacency stores.
// ----------------------------------------------------------------------------
// Store loads, count loads, appends and reads take one word per cycle while
// the block is idle and its output is free; a read result passes from the halo
// RAM through a pending register into the output register, and results wait
// there while the downstream side stalls. A run stalls input while it works:
// it clears the visited map, then visits each core, and in each expansion pass
// reads each source row's count and each stored neighbor; the single visited-map
// port checks them one at a time. After reset a clearing pass zeroes the row
// counts and visited map before the first word is taken.
module core_halo_index_builder #(
    parameter int MAX_ROWS      = 1024,
    parameter int MAX_NEIGHBORS = 32,
    parameter int NODE_DEPTH    = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [9:0]  row,
    input  logic [4:0]  slot,
    input  logic [9:0]  item_value,
    input  logic [5:0]  row_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_run_result,
    output logic [10:0] total_count,
    output logic [10:0] core_count,
    output logic [9:0]  entry,
    output logic        entry_valid,
    output logic        entry_is_core,
    output logic        node_overflow,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    localparam int IDX_W   = $clog2(MAX_ROWS);
    localparam int SLOT_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int NAW     = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int FW      = $clog2(NODE_DEPTH + 1);
    localparam int LW      = IDX_W + 1;
    localparam int JW      = (FW > LW) ? FW : LW;
    localparam int NBR_DEPTH = MAX_ROWS * (2 ** SLOT_W);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CLEAR    = 9'b000000010,
        S_SRC_RD   = 9'b000000100,
        S_SRC_WAIT = 9'b000001000,
        S_CNT      = 9'b000010000,
        S_NBR_RD   = 9'b000100000,
        S_NBR_WAIT = 9'b001000000,
        S_VIS      = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    typedef enum logic [3:0] {
        P_CORE   = 4'b0001,
        P_GRAPH  = 4'b0010,
        P_SECOND = 4'b0100,
        P_DJ     = 4'b1000
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic             init_reg, init_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [JW-1:0]    j_reg, j_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [9:0]       k_reg, k_next;
    logic [LW-1:0]    total_reg, total_next;
    logic [LW-1:0]    core_reg, core_next;
    logic [LW-1:0]    start_reg, start_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             ovf_reg, ovf_next;
    logic             dj_reg, us_reg;

    logic        pend_reg, pend_next;
    logic [10:0] pend_total_reg, pend_total_next;
    logic [10:0] pend_core_reg, pend_core_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        pend_is_core_reg, pend_is_core_next;
    logic        pend_ovf_reg, pend_ovf_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_run_reg, out_run_next;
    logic [10:0] out_total_reg, out_total_next;
    logic [10:0] out_core_reg, out_core_next;
    logic [9:0]  out_entry_reg, out_entry_next;
    logic        out_ev_reg, out_ev_next;
    logic        out_ec_reg, out_ec_next;
    logic        out_ovf_reg, out_ovf_next;

    // RAM ports
    logic                    gn_we, gn_re, sn_we, sn_re;
    logic [IDX_W+SLOT_W-1:0] gn_waddr, gn_raddr, sn_waddr, sn_raddr;
    logic [9:0]              gn_wdata, gn_rdata, sn_wdata, sn_rdata;
    logic                    gc_we, gc_re, sc_we, sc_re;
    logic [IDX_W-1:0]        gc_waddr, gc_raddr, sc_waddr, sc_raddr;
    logic [CNT_W-1:0]        gc_wdata, gc_rdata, sc_wdata, sc_rdata;
    logic                    nl_we, nl_re;
    logic [NAW-1:0]          nl_waddr, nl_raddr;
    logic [9:0]              nl_wdata, nl_rdata;
    logic                    vm_we, vm_re;
    logic [IDX_W-1:0]        vm_waddr, vm_raddr;
    logic [0:0]              vm_wdata, vm_rdata;
    logic                    hl_we, hl_re;
    logic [IDX_W-1:0]        hl_waddr, hl_raddr;
    logic [9:0]              hl_wdata, hl_rdata;

    logic             out_free, accept;
    logic             row_ok, slot_ok, val_ok;
    logic [CNT_W-1:0] cnt_sat;
    logic [JW-1:0]    limit;
    logic [9:0]       src;
    logic [9:0]       nbr;
    logic [CNT_W-1:0] n_rd;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign row_ok  = 32'(row) < MAX_ROWS;
    assign slot_ok = 32'(slot) < MAX_NEIGHBORS;
    assign val_ok  = 32'(item_value) < MAX_ROWS;
    assign cnt_sat = (32'(row_count) > MAX_NEIGHBORS) ? CNT_W'(MAX_NEIGHBORS)
                                                      : CNT_W'(row_count);
    assign limit = (phase_reg == P_DJ) ? JW'(start_reg) : JW'(fill_reg);
    assign src   = (phase_reg == P_DJ) ? hl_rdata : nl_rdata;
    assign nbr   = (phase_reg == P_SECOND) ? sn_rdata : gn_rdata;
    assign n_rd  = (phase_reg == P_SECOND) ? sc_rdata : gc_rdata;

    chib_ram #(.WIDTH(10), .DEPTH(NBR_DEPTH)) u_graph_nbr (
        .clk(clk), .we(gn_we), .waddr(gn_waddr), .wdata(gn_wdata),
        .re(gn_re), .raddr(gn_raddr), .rdata(gn_rdata));
    chib_ram #(.WIDTH(10), .DEPTH(NBR_DEPTH)) u_second_nbr (
        .clk(clk), .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
        .re(sn_re), .raddr(sn_raddr), .rdata(sn_rdata));
    chib_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_graph_cnt (
        .clk(clk), .we(gc_we), .waddr(gc_waddr), .wdata(gc_wdata),
        .re(gc_re), .raddr(gc_raddr), .rdata(gc_rdata));
    chib_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_second_cnt (
        .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
        .re(sc_re), .raddr(sc_raddr), .rdata(sc_rdata));
    chib_ram #(.WIDTH(10), .DEPTH(NODE_DEPTH)) u_node_list (
        .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
        .re(nl_re), .raddr(nl_raddr), .rdata(nl_rdata));
    chib_ram #(.WIDTH(1), .DEPTH(MAX_ROWS)) u_visited (
        .clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
        .re(vm_re), .raddr(vm_raddr), .rdata(vm_rdata));
    chib_ram #(.WIDTH(10), .DEPTH(MAX_ROWS)) u_halo (
        .clk(clk), .we(hl_we), .waddr(hl_waddr), .wdata(hl_wdata),
        .re(hl_re), .raddr(hl_raddr), .rdata(hl_rdata));

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        init_next  = init_reg;
        clr_next   = clr_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        total_next = total_reg;
        core_next  = core_reg;
        start_next = start_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;

        pend_next         = pend_reg;
        pend_total_next   = pend_total_reg;
        pend_core_next    = pend_core_reg;
        pend_valid_next   = pend_valid_reg;
        pend_is_core_next = pend_is_core_reg;
        pend_ovf_next     = pend_ovf_reg;

        out_valid_next = out_valid_reg;
        out_run_next   = out_run_reg;
        out_total_next = out_total_reg;
        out_core_next  = out_core_reg;
        out_entry_next = out_entry_reg;
        out_ev_next    = out_ev_reg;
        out_ec_next    = out_ec_reg;
        out_ovf_next   = out_ovf_reg;

        gn_we = 1'b0; gn_waddr = {IDX_W'(row), SLOT_W'(slot)}; gn_wdata = item_value;
        sn_we = 1'b0; sn_waddr = {IDX_W'(row), SLOT_W'(slot)}; sn_wdata = item_value;
        gn_re = 1'b0; gn_raddr = {r_reg, SLOT_W'(s_reg)};
        sn_re = 1'b0; sn_raddr = {r_reg, SLOT_W'(s_reg)};
        gc_we = 1'b0; gc_waddr = IDX_W'(row); gc_wdata = cnt_sat;
        sc_we = 1'b0; sc_waddr = IDX_W'(row); sc_wdata = cnt_sat;
        gc_re = 1'b0; gc_raddr = IDX_W'(src);
        sc_re = 1'b0; sc_raddr = IDX_W'(src);
        nl_we = 1'b0; nl_waddr = NAW'(fill_reg); nl_wdata = item_value;
        nl_re = 1'b0; nl_raddr = NAW'(j_reg);
        vm_we = 1'b0; vm_waddr = clr_reg; vm_wdata = 1'b0;
        vm_re = 1'b0; vm_raddr = IDX_W'(nbr);
        hl_we = 1'b0; hl_waddr = IDX_W'(total_reg); hl_wdata = k_reg;
        hl_re = 1'b0; hl_raddr = IDX_W'(item_value);

        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (pend_reg)
            begin
                pend_next      = 1'b0;
                out_valid_next = 1'b1;
                out_run_next   = 1'b0;
                out_total_next = pend_total_reg;
                out_core_next  = pend_core_reg;
                out_entry_next = pend_valid_reg ? hl_rdata : 10'd0;
                out_ev_next    = pend_valid_reg;
                out_ec_next    = pend_is_core_reg;
                out_ovf_next   = pend_ovf_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        chib_pkg::OP_GRAPH_NBR:  gn_we = row_ok && slot_ok;
                        chib_pkg::OP_SECOND_NBR: sn_we = row_ok && slot_ok;
                        chib_pkg::OP_GRAPH_CNT:  gc_we = row_ok;
                        chib_pkg::OP_SECOND_CNT: sc_we = row_ok;
                        chib_pkg::OP_APPEND:
                        begin
                            if (val_ok)
                            begin
                                if (32'(fill_reg) < NODE_DEPTH)
                                begin
                                    nl_we     = 1'b1;
                                    fill_next = fill_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        chib_pkg::OP_RUN:
                        begin
                            state_next = S_CLEAR;
                            clr_next   = '0;
                            total_next = '0;
                        end
                        chib_pkg::OP_READ:
                        begin
                            hl_re             = 1'b1;
                            pend_next         = 1'b1;
                            pend_total_next   = 11'(total_reg);
                            pend_core_next    = 11'(core_reg);
                            pend_valid_next   = (32'(item_value) < 32'(total_reg)) && val_ok;
                            pend_is_core_next = 32'(item_value) < 32'(core_reg);
                            pend_ovf_next     = ovf_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                vm_we    = 1'b1;
                gc_waddr = clr_reg;
                sc_waddr = clr_reg;
                gc_wdata = '0;
                sc_wdata = '0;
                gc_we    = init_reg;
                sc_we    = init_reg;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == MAX_ROWS - 1)
                begin
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        phase_next = P_CORE;
                        j_next     = '0;
                        state_next = S_SRC_RD;
                    end
                end
            end
            S_SRC_RD:
            begin
                if (j_reg < limit)
                begin
                    nl_re      = (phase_reg != P_DJ);
                    hl_re      = (phase_reg == P_DJ);
                    hl_raddr   = IDX_W'(j_reg);
                    state_next = S_SRC_WAIT;
                end
                else
                begin
                    j_next = '0;
                    unique case (phase_reg)
                        P_CORE:
                        begin
                            core_next  = total_reg;
                            phase_next = P_GRAPH;
                        end
                        P_GRAPH, P_SECOND:
                        begin
                            start_next = total_reg;
                            if (phase_reg == P_GRAPH && us_reg)
                            begin
                                phase_next = P_SECOND;
                            end
                            else if (dj_reg)
                            begin
                                phase_next = P_DJ;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_SRC_WAIT:
            begin
                if (phase_reg == P_CORE)
                begin
                    k_next     = src;
                    vm_re      = 1'b1;
                    vm_raddr   = IDX_W'(src);
                    state_next = S_VIS;
                end
                else if (32'(src) < MAX_ROWS)
                begin
                    r_next     = IDX_W'(src);
                    gc_re      = (phase_reg != P_SECOND);
                    sc_re      = (phase_reg == P_SECOND);
                    state_next = S_CNT;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SRC_RD;
                end
            end
            S_CNT:
            begin
                n_next = n_rd;
                s_next = '0;
                if (n_rd == '0)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SRC_RD;
                end
                else
                begin
                    state_next = S_NBR_RD;
                end
            end
            S_NBR_RD:
            begin
                gn_re      = (phase_reg != P_SECOND);
                sn_re      = (phase_reg == P_SECOND);
                state_next = S_NBR_WAIT;
            end
            S_NBR_WAIT:
            begin
                k_next     = nbr;
                vm_re      = 1'b1;
                state_next = S_VIS;
            end
            S_VIS:
            begin
                if ((32'(k_reg) < MAX_ROWS) && !vm_rdata[0]
                    && (32'(total_reg) < MAX_ROWS))
                begin
                    vm_we      = 1'b1;
                    vm_waddr   = IDX_W'(k_reg);
                    vm_wdata   = 1'b1;
                    hl_we      = 1'b1;
                    total_next = total_reg + 1'b1;
                end
                if (phase_reg == P_CORE || (s_reg + 1'b1) >= n_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SRC_RD;
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = S_NBR_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_run_next   = 1'b1;
                    out_total_next = 11'(total_reg);
                    out_core_next  = 11'(core_reg);
                    out_entry_next = '0;
                    out_ev_next    = 1'b0;
                    out_ec_next    = 1'b0;
                    out_ovf_next   = ovf_reg;
                    ovf_next       = 1'b0;
                    fill_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            phase_reg     <= P_CORE;
            init_reg      <= 1'b1;
            clr_reg       <= '0;
            j_reg         <= '0;
            s_reg         <= '0;
            total_reg     <= '0;
            core_reg      <= '0;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            dj_reg        <= 1'b0;
            us_reg        <= 1'b1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            init_reg      <= init_next;
            clr_reg       <= clr_next;
            j_reg         <= j_next;
            s_reg         <= s_next;
            total_reg     <= total_next;
            core_reg      <= core_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == chib_pkg::CFG_DOUBLE_JUMP)
                begin
                    dj_reg <= cfg_data;
                end
                else
                begin
                    us_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg            <= n_next;
        r_reg            <= r_next;
        k_reg            <= k_next;
        start_reg        <= start_next;
        pend_total_reg   <= pend_total_next;
        pend_core_reg    <= pend_core_next;
        pend_valid_reg   <= pend_valid_next;
        pend_is_core_reg <= pend_is_core_next;
        pend_ovf_reg     <= pend_ovf_next;
        out_run_reg      <= out_run_next;
        out_total_reg    <= out_total_next;
        out_core_reg     <= out_core_next;
        out_entry_reg    <= out_entry_next;
        out_ev_reg       <= out_ev_next;
        out_ec_reg       <= out_ec_next;
        out_ovf_reg      <= out_ovf_next;
    end

    assign out_valid     = out_valid_reg;
    assign is_run_result = out_run_reg;
    assign total_count   = out_total_reg;
    assign core_count    = out_core_reg;
    assign entry         = out_entry_reg;
    assign entry_valid   = out_ev_reg;
    assign entry_is_core = out_ec_reg;
    assign node_overflow = out_ovf_reg;

endmodule

[design/chib_checker.sv]
// ----------------------------------------------------------------------------
// chib_checker
// Port-level checks for the halo index builder, bound to the top level.
// ----------------------------------------------------------------------------
module chib_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  op,
    input logic        out_valid,
    input logic        out_stall,
    input logic        is_run_result,
    input logic [10:0] total_count,
    input logic [10:0] core_count,
    input logic [9:0]  entry,
    input logic        entry_valid,
    input logic        entry_is_core
);

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == chib_pkg::OP_RUN |=> in_stall)
        else $error("input taken right after a run word");

    a_run_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_run_result |-> !entry_valid && !entry_is_core && entry == 10'd0)
        else $error("run result carries entry fields");

    a_core_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_is_core |-> entry_valid && core_count <= total_count)
        else $error("core entry outside the list");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(total_count) && $stable(entry))
        else $error("stalled result word changed");

endmodule

bind core_halo_index_builder chib_checker u_chib_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .out_valid(out_valid), .out_stall(out_stall), .is_run_result(is_run_result),
    .total_count(total_count), .core_count(core_count), .entry(entry),
    .entry_valid(entry_valid), .entry_is_core(entry_is_core));
